/* rtl/multi_stack_engine_defines.svh */
// ----------------------------------------------------------------------------
// Multi-stack engine assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_STACK_ENGINE_DEFINES_SVH
`define MULTI_STACK_ENGINE_DEFINES_SVH

// Same-cycle implication: whenever ant holds, cons must hold in that cycle.
`define MSE_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("multi_stack_engine: same-cycle check failed");

// Next-cycle implication: whenever ant holds, cons must hold in the next cycle.
`define MSE_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("multi_stack_engine: next-cycle check failed");

`endif

/* rtl/mse_pkg.sv */
// ----------------------------------------------------------------------------
// Multi-stack engine package
// Sizing constants, command and status codes, and the structs passed between
// the control unit and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mse_pkg;

  // Sizing of the stack array.
  localparam int NUM_STACKS  = 3;
  localparam int STACK_DEPTH = 16;
  localparam int DATA_WIDTH  = 16;

  // Fixed field widths of the request and result items.
  localparam int CMD_W = 2;
  localparam int IDX_W = 2;
  localparam int VAL_W = 16;
  localparam int RD_W  = 16;
  localparam int STS_W = 2;

  // Derived widths.
  localparam int TOTAL_WORDS = NUM_STACKS * STACK_DEPTH;
  localparam int ADDR_W      = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int SID_W       = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int SEL_W       = (SID_W > IDX_W) ? SID_W : IDX_W;

  // Request operations.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_e;

  // Result status codes.
  typedef enum logic [STS_W-1:0] {
    STS_DONE  = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_e;

  // Access issued to the stack memory for one request.
  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [ADDR_W-1:0]     addr;
    logic [DATA_WIDTH-1:0] wdata;
  } mem_req_t;

  // Result fields known when the request is taken, before the memory answers.
  typedef struct packed {
    logic    rd_en;
    status_e status;
    logic    now_empty;
    logic    now_full;
  } res_t;

endpackage

`default_nettype wire

/* rtl/multi_stack_engine.sv */
// Flow: a taken request accesses the stack memory through its registered read
//   port while its early fields wait in pend_q; the output register then takes
//   the result when it is free. A new request is taken only after that hand-off.
// Reset: all entry counts clear, so every stack is empty; the stack memory is
//   not cleared and needs no clearing pass, the block is ready at once.
// ----------------------------------------------------------------------------
// Multi-stack engine
// Several fixed-depth stacks in one shared memory, served by push, pop and
// peek requests on a stream interface, one result per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "multi_stack_engine_defines.svh"

module multi_stack_engine import mse_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request stream.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,  // [15:0] push_value
  input  wire logic [3:0]  s_axis_tuser_i,  // [1:0] cmd, [3:2] stack_index
  // Result stream.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,  // [15:0] read_data
  output logic [3:0]       m_axis_tuser_o   // [1:0] status, [2] now_empty, [3] now_full
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_BUSY = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic              take;
  logic              out_load;
  mem_req_t          mem_req;
  res_t              res;
  res_t              pend_q;
  logic [DATA_WIDTH-1:0] rdata;
  logic              m_valid_q;
  logic [RD_W-1:0]   m_data_q;
  logic [3:0]        m_user_q;

  // A request is taken only with no other request in flight, which also
  // keeps a write and a later read of the same word from overlapping.
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign take            = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = (state_q == S_BUSY) && (!m_valid_q || m_axis_tready_i);

  mse_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .cmd_i         (s_axis_tuser_i[1:0]),
    .stack_index_i (s_axis_tuser_i[3:2]),
    .push_value_i  (s_axis_tdata_i),
    .mem_req_o     (mem_req),
    .res_o         (res)
  );

  mse_ram #(
    .DEPTH  (TOTAL_WORDS),
    .WIDTH  (DATA_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .re_i    (mem_req.re),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (rdata)
  );

  // Sequencer: take a request, then hand its result to the output register.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (take) begin
          state_d = S_BUSY;
        end
      end
      S_BUSY: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Early result fields wait here for the memory read data.
  always_ff @(posedge clk_i) begin
    if (take) begin
      pend_q <= res;
    end
  end

  // Output register; it holds a result while the next request is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= pend_q.rd_en ? RD_W'(rdata) : '0;
      m_user_q <= {pend_q.now_full, pend_q.now_empty, pend_q.status};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  // A taken request always occupies the sequencer in the next cycle.
  `MSE_ASSERT_NEXT(a_take_busy, take, state_q == S_BUSY)

  // Only a successful pop or peek can carry nonzero data.
  `MSE_ASSERT_NOW(a_fail_no_data,
      m_axis_tvalid_o && (m_axis_tuser_o[1:0] != STS_DONE), m_axis_tdata_o == '0)

  // A stack cannot be empty and full at the same time.
  `MSE_ASSERT_NOW(a_flags_excl, m_axis_tvalid_o, !(m_axis_tuser_o[2] && m_axis_tuser_o[3]))

  // A dropped push leaves the stack full.
  `MSE_ASSERT_NOW(a_full_flag,
      m_axis_tvalid_o && (m_axis_tuser_o[1:0] == STS_FULL), m_axis_tuser_o[3])

endmodule

`default_nettype wire

/* rtl/mse_ram.sv */
// ----------------------------------------------------------------------------
// Multi-stack engine storage RAM
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mse_ram #(
  parameter int DEPTH  = 48,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read share the single address port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/mse_ctrl.sv */
// ----------------------------------------------------------------------------
// Multi-stack engine control
// Holds the per-stack entry counts, decodes a request, and issues the memory
// access and the early result fields for it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mse_ctrl import mse_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             take_i,
  input  wire logic [CMD_W-1:0] cmd_i,
  input  wire logic [IDX_W-1:0] stack_index_i,
  input  wire logic [VAL_W-1:0] push_value_i,
  output mem_req_t              mem_req_o,
  output res_t                  res_o
);

  logic [CNT_W-1:0]  counts_q [NUM_STACKS];
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_d;
  logic [SEL_W-1:0]  sel_wide;
  logic [SID_W-1:0]  sel;
  logic              idx_ok;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] push_addr;
  logic [ADDR_W-1:0] top_addr;

  // Stack selection and its base address in the shared store.
  assign sel_wide  = SEL_W'(stack_index_i);
  assign idx_ok    = (sel_wide < SEL_W'(NUM_STACKS));
  assign sel       = sel_wide[SID_W-1:0];
  assign cnt       = idx_ok ? counts_q[sel] : '0;
  assign base      = ADDR_W'(sel) * ADDR_W'(STACK_DEPTH);
  assign push_addr = base + ADDR_W'(cnt);
  assign top_addr  = push_addr - ADDR_W'(1);

  // Request decode.
  always_comb begin
    mem_req_o.we    = 1'b0;
    mem_req_o.re    = 1'b0;
    mem_req_o.addr  = top_addr;
    mem_req_o.wdata = push_value_i[DATA_WIDTH-1:0];
    res_o.rd_en     = 1'b0;
    res_o.status    = STS_DONE;
    cnt_d           = cnt;
    if (!idx_ok) begin
      // A stack outside the array reads as permanently empty.
      res_o.status = STS_EMPTY;
    end else begin
      case (cmd_i)
        CMD_PUSH: begin
          mem_req_o.addr = push_addr;
          if (cnt == CNT_W'(STACK_DEPTH)) begin
            res_o.status = STS_FULL;
          end else begin
            mem_req_o.we = take_i;
            cnt_d        = cnt + CNT_W'(1);
          end
        end
        CMD_POP, CMD_PEEK: begin
          if (cnt == '0) begin
            res_o.status = STS_EMPTY;
          end else begin
            mem_req_o.re = take_i;
            res_o.rd_en  = 1'b1;
            if (cmd_i == CMD_POP) begin
              cnt_d = cnt - CNT_W'(1);
            end
          end
        end
        default: begin
          // Unused command code: no operation, flags still reported.
        end
      endcase
    end
    // Flags describe the addressed stack after the step.
    res_o.now_empty = (cnt_d == '0);
    res_o.now_full  = (cnt_d == CNT_W'(STACK_DEPTH));
  end

  // Entry counts, updated when a request is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        counts_q[i] <= '0;
      end
    end else if (take_i && idx_ok) begin
      counts_q[sel] <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* tb/multi_stack_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-stack engine testbench
// Sends push, pop and peek requests, also to unused stacks and with the unused
// command code, and checks every result against typed directed expectations or
// a behavioral stack model. Both stream sides idle at random. The receiver
// holds off for a long stretch once, and the sender drains the engine once.
// ----------------------------------------------------------------------------
module multi_stack_engine_tb;
  import mse_pkg::*;

  // Spare command code with no operation, and an index past the last stack.
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;
  localparam logic [IDX_W-1:0] BAD_STACK = 2'd3;

  localparam int RANDOM_REQUESTS = 1950;
  localparam int RECV_HOLD_CYCLES = 200;
  localparam int MAX_REPORTS = 100;
  localparam int TIMEOUT_NS = 400_000;

  // One result as seen on the master side.
  typedef struct packed {
    logic [RD_W-1:0] read_data;
    status_e         status;
    logic            now_empty;
    logic            now_full;
  } stack_result_t;

  // One row of the directed sequence.
  typedef struct {
    logic [CMD_W-1:0] op;
    logic [IDX_W-1:0] sid;
    logic [VAL_W-1:0] value;
    int               reps;
    bit               typed;
    stack_result_t    want;
  } plan_row_t;

  localparam stack_result_t FROM_MODEL = '{16'h0000, STS_DONE, 1'b0, 1'b0};

  // Directed sequence: empty reads, unused stack and command, extremes of the
  // data, then one stack filled to the top and a push onto the full stack.
  plan_row_t directed_plan [18] = '{
    '{CMD_POP,  2'd0,      16'h0000, 1,  1'b1, '{16'h0000, STS_EMPTY, 1'b1, 1'b0}},
    '{CMD_PEEK, 2'd1,      16'h0000, 1,  1'b1, '{16'h0000, STS_EMPTY, 1'b1, 1'b0}},
    '{CMD_NOP,  2'd2,      16'hFFFF, 1,  1'b1, '{16'h0000, STS_DONE,  1'b1, 1'b0}},
    '{CMD_PUSH, BAD_STACK, 16'hFFFF, 1,  1'b1, '{16'h0000, STS_EMPTY, 1'b1, 1'b0}},
    '{CMD_POP,  BAD_STACK, 16'h0000, 1,  1'b1, '{16'h0000, STS_EMPTY, 1'b1, 1'b0}},
    '{CMD_PEEK, BAD_STACK, 16'h0000, 1,  1'b1, '{16'h0000, STS_EMPTY, 1'b1, 1'b0}},
    '{CMD_NOP,  BAD_STACK, 16'h0000, 1,  1'b1, '{16'h0000, STS_EMPTY, 1'b1, 1'b0}},
    '{CMD_PUSH, 2'd0,      16'h0000, 1,  1'b1, '{16'h0000, STS_DONE,  1'b0, 1'b0}},
    '{CMD_PUSH, 2'd0,      16'hFFFF, 1,  1'b1, '{16'h0000, STS_DONE,  1'b0, 1'b0}},
    '{CMD_PEEK, 2'd0,      16'h0000, 1,  1'b1, '{16'hFFFF, STS_DONE,  1'b0, 1'b0}},
    '{CMD_POP,  2'd0,      16'h0000, 1,  1'b1, '{16'hFFFF, STS_DONE,  1'b0, 1'b0}},
    '{CMD_POP,  2'd0,      16'h0000, 1,  1'b1, '{16'h0000, STS_DONE,  1'b1, 1'b0}},
    '{CMD_PUSH, 2'd2,      16'hA5C3, 16, 1'b0, FROM_MODEL},
    '{CMD_PUSH, 2'd2,      16'h1234, 1,  1'b1, '{16'h0000, STS_FULL,  1'b0, 1'b1}},
    '{CMD_NOP,  2'd2,      16'h0000, 1,  1'b1, '{16'h0000, STS_DONE,  1'b0, 1'b1}},
    '{CMD_PEEK, 2'd2,      16'h0000, 1,  1'b0, FROM_MODEL},
    '{CMD_POP,  2'd2,      16'h0000, 1,  1'b0, FROM_MODEL},
    '{CMD_PUSH, 2'd1,      16'h5A5A, 1,  1'b0, FROM_MODEL}
  };

  logic              clk;
  logic              rst_n   = 1'b0;
  logic              s_valid = 1'b0;
  logic [15:0]       s_data  = '0;
  logic [3:0]        s_user  = '0;
  logic              m_ready = 1'b0;
  wire               s_ready;
  wire               m_valid;
  wire [15:0]        m_data;
  wire [3:0]         m_user;

  // Behavioral copy of the stacks and their fill levels.
  logic [DATA_WIDTH-1:0] shadow_stack [NUM_STACKS][STACK_DEPTH];
  int unsigned           shadow_depth [NUM_STACKS];

  stack_result_t pending_results [$];

  bit calm     = 1'b0;
  bit hold_req = 1'b0;
  int fault_count     = 0;
  int requests_sent   = 0;
  int results_checked = 0;
  int dropped_pushes  = 0;
  int empty_reads     = 0;
  int full_seen       = 0;

  multi_stack_engine dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #(TIMEOUT_NS);
    $display("multi_stack_engine: mismatch");
    $finish;
  end

  // Works out the result of one request and updates the stack copy.
  function automatic stack_result_t predict_stack_op(input logic [CMD_W-1:0] op,
                                                     input logic [IDX_W-1:0] sid,
                                                     input logic [VAL_W-1:0] value);
    stack_result_t res;
    int unsigned   fill;
    res = '{'0, STS_DONE, 1'b0, 1'b0};
    // An unused stack looks permanently empty and never takes data.
    if (sid >= NUM_STACKS) begin
      res.status    = STS_EMPTY;
      res.now_empty = 1'b1;
      return res;
    end
    fill = shadow_depth[sid];
    case (op)
      CMD_PUSH: begin
        if (fill >= STACK_DEPTH) begin
          res.status = STS_FULL;
        end else begin
          shadow_stack[sid][fill] = value[DATA_WIDTH-1:0];
          shadow_depth[sid] = fill + 1;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (fill == 0) begin
          res.status = STS_EMPTY;
        end else begin
          res.read_data = RD_W'(shadow_stack[sid][fill-1]);
          if (op == CMD_POP) shadow_depth[sid] = fill - 1;
        end
      end
      default: ;
    endcase
    res.now_empty = (shadow_depth[sid] == 0);
    res.now_full  = (shadow_depth[sid] >= STACK_DEPTH);
    return res;
  endfunction

  // Offers one request, waits for its transfer and records the expected result.
  task automatic issue_request(input logic [CMD_W-1:0] op, input logic [IDX_W-1:0] sid,
                               input logic [VAL_W-1:0] value, input bit typed,
                               input stack_result_t want);
    stack_result_t predicted;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= {sid, op};
    s_data  <= value;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    predicted = predict_stack_op(op, sid, value);
    pending_results.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= MAX_REPORTS)
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    wait (rst_n);
    forever begin
      if (hold_req) begin
        m_ready <= 1'b0;
        repeat (RECV_HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        m_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n && m_valid && m_ready) begin
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $error("result transfer with nothing expected: data 0x%0h user 0x%0h",
                 m_data, m_user);
      end else begin
        want = pending_results.pop_front();
        check_field("read_data", want.read_data, m_data);
        check_field("status", 16'(want.status), 16'(m_user[1:0]));
        check_field("now_empty", 16'(want.now_empty), 16'(m_user[2]));
        check_field("now_full", 16'(want.now_full), 16'(m_user[3]));
        results_checked++;
        if (want.status == STS_FULL) dropped_pushes++;
        if (want.status == STS_EMPTY) empty_reads++;
        if (want.now_full) full_seen++;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [CMD_W-1:0] op;
    logic [IDX_W-1:0] sid;
    logic [VAL_W-1:0] value;
    int               push_pct;
    int               roll;
    for (int s = 0; s < NUM_STACKS; s++) shadow_depth[s] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sequence.
    foreach (directed_plan[r]) begin
      for (int k = 0; k < directed_plan[r].reps; k++) begin
        issue_request(directed_plan[r].op, directed_plan[r].sid,
                      directed_plan[r].value + VAL_W'(k), directed_plan[r].typed,
                      directed_plan[r].want);
      end
    end

    // Random traffic in phases that lean toward filling or draining.
    push_pct = 50;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 150 == 0) begin
        case ($urandom_range(0, 3))
          0: push_pct = 10;
          1: push_pct = 50;
          2: push_pct = 55;
          default: push_pct = 92;
        endcase
      end
      calm = (i >= 600 && i < 760) || (i >= RANDOM_REQUESTS - 250);
      // Long receiver hold-off while requests keep coming.
      if (i == 400) hold_req = 1'b1;
      // Sender waits here until every result is back.
      if (i == 1000) begin
        s_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) op = CMD_NOP;
      else if (roll < 4 + push_pct * 92 / 100) op = CMD_PUSH;
      else if ($urandom_range(0, 2) == 0) op = CMD_PEEK;
      else op = CMD_POP;
      if ($urandom_range(0, 24) == 0) sid = BAD_STACK;
      else sid = IDX_W'($urandom_range(0, NUM_STACKS - 1));
      case ($urandom_range(0, 7))
        0: value = '0;
        1: value = '1;
        default: value = VAL_W'($urandom);
      endcase
      issue_request(op, sid, value, 1'b0, FROM_MODEL);
    end
    s_valid <= 1'b0;

    // Let the last results drain, then watch for stray transfers.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d requests and checked %0d results across %0d stacks.",
             requests_sent, results_checked, NUM_STACKS);
    $display("Saw %0d dropped pushes, %0d empty reads, %0d results with a full stack.",
             dropped_pushes, empty_reads, full_seen);
    if (fault_count == 0) begin
      $display("multi_stack_engine: match");
    end else begin
      $display("multi_stack_engine: mismatch");
    end
    $finish;
  end

endmodule
